// ===== hw/rtl/mbq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_pkg: shared types and constants of the multichannel biquad filter
// Widths of the stream fields, the coefficient set, the per-channel history
// word and the configuration register map.
// ----------------------------------------------------------------------------
package mbq_pkg;

    localparam int CH_W           = 3;
    localparam int SAMPLE_W       = 24;
    localparam int COEF_W         = 32;
    localparam int ENABLE_W       = 8;
    localparam int REG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int PROD_W         = COEF_W + SAMPLE_W;
    // Five products plus the rounding term, with headroom for the sign.
    localparam int ACC_W          = PROD_W + 4;

    localparam int SAMPLE_MAX     = 8388607;
    localparam int SAMPLE_MIN     = -8388608;

    localparam int DEF_CHANNELS       = 8;
    localparam int DEF_COEF_FRAC_BITS = 28;

    localparam logic [COEF_W-1:0]   B0_RESET     = 32'h1000_0000;
    localparam logic [ENABLE_W-1:0] ENABLE_RESET = '0;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_A1     = 3'd3,
        REG_A2     = 3'd4,
        REG_ENABLE = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } coef_set_t;

    // One history word per channel: two past inputs and two past outputs.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } hist_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] ch;
        hist_t           data;
    } hist_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_in_if / mbq_out_if: valid/ready stream channels of the biquad filter
// The input channel carries a tagged sample, the output channel its result.
// ----------------------------------------------------------------------------
interface mbq_in_if import mbq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_sample;

    modport source (output valid, output channel, output sample_in,
                    output last_sample, input ready);
    modport sink   (input valid, input channel, input sample_in,
                    input last_sample, output ready);
endinterface

interface mbq_out_if import mbq_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel_out;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;

    modport source (output valid, output channel_out, output sample_out,
                    output last_out, input ready);
    modport sink   (input valid, input channel_out, input sample_out,
                    input last_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbq_hist_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_hist_mem: per-channel filter history memory
// One entry per channel, one read and one write port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset, and
// a same-cycle write to the entry being read is passed straight through.
// ----------------------------------------------------------------------------
module mbq_hist_mem import mbq_pkg::*; #(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            rd_en,
    input  wire logic [CH_W-1:0] rd_ch,
    output hist_t                rd_data,
    input  wire hist_wr_t        wr
);

    localparam int MEM_DEPTH = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    hist_t                  hist_mem_reg [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]   valid_reg;
    hist_t                  rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;

    assign rd_addr = rd_ch[ADDR_W-1:0];
    assign wr_addr = wr.ch[ADDR_W-1:0];
    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            hist_mem_reg[wr_addr] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else if (valid_reg[rd_addr])
            begin
                rd_data_reg <= hist_mem_reg[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mbq_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbq_mac: biquad multiply and accumulate
// Registers the five coefficient products, then sums them, rounds to nearest
// and saturates the result to the sample width.
// ----------------------------------------------------------------------------
module mbq_mac import mbq_pkg::*; #(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire logic signed [SAMPLE_W-1:0] x,
    input  wire hist_t                      hist,
    input  wire coef_set_t                  coefs,
    output logic signed [SAMPLE_W-1:0]      y_sat
);

    logic signed [PROD_W-1:0] p_b0_reg;
    logic signed [PROD_W-1:0] p_b1_reg;
    logic signed [PROD_W-1:0] p_b2_reg;
    logic signed [PROD_W-1:0] p_a1_reg;
    logic signed [PROD_W-1:0] p_a2_reg;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [ACC_W-1:0]  shifted;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] LIMIT_HI   = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] LIMIT_LO   = ACC_W'(SAMPLE_MIN);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_b0_reg <= coefs.b0 * x;
            p_b1_reg <= coefs.b1 * hist.x1;
            p_b2_reg <= coefs.b2 * hist.x2;
            p_a1_reg <= coefs.a1 * hist.y1;
            p_a2_reg <= coefs.a2 * hist.y2;
        end
    end

    always_comb
    begin
        acc = ACC_W'(p_b0_reg) + ACC_W'(p_b1_reg) + ACC_W'(p_b2_reg)
            - ACC_W'(p_a1_reg) - ACC_W'(p_a2_reg);
        rounded = acc + ROUND_BIAS;
        // Arithmetic shift floors, so ties go toward plus infinity.
        shifted = rounded >>> COEF_FRAC_BITS;
        if (shifted > LIMIT_HI)
        begin
            y_sat = LIMIT_HI[SAMPLE_W-1:0];
        end
        else if (shifted < LIMIT_LO)
        begin
            y_sat = LIMIT_LO[SAMPLE_W-1:0];
        end
        else
        begin
            y_sat = shifted[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_biquad_filter.sv =====
`default_nettype none
// Path: an accepted input beat moves through S1 and S2 into the output register.
// Throughput: one beat per cycle while the output does not stall and consecutive beats
// belong to different channels; two beats of the same enabled channel are not accepted
// back to back: the next may not read history until the previous result is written.
// Reset: coefficients return to pass-through (b0 = 1.0), all channels disabled,
// and all history reads as zero right away through per-entry valid bits.
// ----------------------------------------------------------------------------
// multichannel_biquad_filter: interleaved direct form 1 biquad
// Filters tagged 24-bit audio samples with one shared set of Q4.28
// coefficients and per-channel history held in a small memory.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter import mbq_pkg::*; #(
    parameter int CHANNELS       = DEF_CHANNELS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mbq_in_if.sink                     samples,
    mbq_out_if.source                  filtered,
    input  wire logic                  write_enable,
    input  wire logic [REG_IDX_W-1:0]  reg_index,
    input  wire logic [CFG_DATA_W-1:0] write_data
);

    // The pipeline has three stages:
    //   S1  the history read issued at the accepting edge returns; the five
    //       products are formed and registered.
    //   S2  the products are summed, rounded and saturated; the new history
    //       word is written back when the beat moves on to the output.
    //   OUT the output register, which lets the pipeline keep accepting beats
    //       while a finished result waits on the sink.
    // A beat whose channel matches an enabled beat still in S1, or one held in
    // S2, is not accepted; a beat accepted at the same edge as the write-back
    // sees the new history through the memory bypass.

    coef_set_t               coef_reg;
    logic [ENABLE_W-1:0]     enable_reg;

    logic                       s1_v_reg;
    logic [CH_W-1:0]            s1_ch_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    logic                       s1_last_reg;
    logic                       s1_en_reg;

    logic                       s2_v_reg;
    logic [CH_W-1:0]            s2_ch_reg;
    logic signed [SAMPLE_W-1:0] s2_x_reg;
    logic signed [SAMPLE_W-1:0] s2_x1_reg;
    logic signed [SAMPLE_W-1:0] s2_y1_reg;
    logic                       s2_last_reg;
    logic                       s2_en_reg;

    logic                       out_v_reg;
    logic [CH_W-1:0]            out_ch_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;

    logic                       s1_v_next;
    logic                       s2_v_next;
    logic                       out_v_next;

    logic                       out_free;
    logic                       s2_adv;
    logic                       s2_free;
    logic                       s1_adv;
    logic                       s1_free;
    logic                       hazard;
    logic                       in_fire;
    logic                       in_en;

    hist_t                      hist_rd;
    hist_wr_t                   hist_wr;
    logic signed [SAMPLE_W-1:0] y_sat;

    // Config registers: the user must write only while the pipeline is idle; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= B0_RESET;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
            enable_reg  <= ENABLE_RESET;
        end
        else if (write_enable)
        begin
            unique case (reg_index_t'(reg_index))
                REG_B0:     coef_reg.b0 <= write_data;
                REG_B1:     coef_reg.b1 <= write_data;
                REG_B2:     coef_reg.b2 <= write_data;
                REG_A1:     coef_reg.a1 <= write_data;
                REG_A2:     coef_reg.a2 <= write_data;
                REG_ENABLE: enable_reg  <= write_data[ENABLE_W-1:0];
                default:    ;
            endcase
        end
    end

    // Flow control, from the output back to the input.
    assign out_free = !out_v_reg || filtered.ready;
    assign s2_adv   = s2_v_reg && out_free;
    assign s2_free  = !s2_v_reg || out_free;
    assign s1_adv   = s1_v_reg && s2_free;
    assign s1_free  = !s1_v_reg || s2_free;

    // Read-after-write interlock on the history of one channel. A beat in S2
    // that leaves at this edge writes its history at the same edge, and the
    // memory bypass covers that case.
    assign hazard = (s1_v_reg && s1_en_reg && (s1_ch_reg == samples.channel))
                 || (s2_v_reg && s2_en_reg && (s2_ch_reg == samples.channel) && !s2_adv);

    assign samples.ready = s1_free && !hazard;
    assign in_fire       = samples.valid && samples.ready;

    // Channels at or beyond the configured count are always passed through.
    assign in_en = (int'(samples.channel) < CHANNELS) && enable_reg[samples.channel];

    assign s1_v_next  = in_fire || (s1_v_reg && !s1_adv);
    assign s2_v_next  = s1_adv || (s2_v_reg && !s2_adv);
    assign out_v_next = s2_adv || (out_v_reg && !filtered.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // Stage payloads carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ch_reg   <= samples.channel;
            s1_x_reg    <= samples.sample_in;
            s1_last_reg <= samples.last_sample;
            s1_en_reg   <= in_en;
        end
        if (s1_adv)
        begin
            s2_ch_reg   <= s1_ch_reg;
            s2_x_reg    <= s1_x_reg;
            s2_x1_reg   <= hist_rd.x1;
            s2_y1_reg   <= hist_rd.y1;
            s2_last_reg <= s1_last_reg;
            s2_en_reg   <= s1_en_reg;
        end
        if (s2_adv)
        begin
            out_ch_reg     <= s2_ch_reg;
            out_sample_reg <= s2_en_reg ? y_sat : s2_x_reg;
            out_last_reg   <= s2_last_reg;
        end
    end

    // History write-back: the current input and output shift into the
    // one-sample-back slots, the old ones into the two-samples-back slots.
    // A passed-through beat leaves its channel's history untouched.
    always_comb
    begin
        hist_wr.en      = s2_adv && s2_en_reg;
        hist_wr.ch      = s2_ch_reg;
        hist_wr.data.x1 = s2_x_reg;
        hist_wr.data.x2 = s2_x1_reg;
        hist_wr.data.y1 = y_sat;
        hist_wr.data.y2 = s2_y1_reg;
    end

    mbq_hist_mem #(
        .CHANNELS (CHANNELS)
    ) u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_ch   (samples.channel),
        .rd_data (hist_rd),
        .wr      (hist_wr)
    );

    mbq_mac #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .load  (s1_adv),
        .x     (s1_x_reg),
        .hist  (hist_rd),
        .coefs (coef_reg),
        .y_sat (y_sat)
    );

    assign filtered.valid       = out_v_reg;
    assign filtered.channel_out = out_ch_reg;
    assign filtered.sample_out  = out_sample_reg;
    assign filtered.last_out    = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/multichannel_biquad_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multichannel_biquad_filter_tb: self-checking bench for the biquad filter
// Drives tagged samples and coefficient writes into the filter and predicts
// every output beat with a behavioral biquad that keeps its own history.
// Output beats are compared in order, field by field.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter_tb;
    import mbq_pkg::*;

    localparam int CHANNELS    = DEF_CHANNELS;
    localparam int FRAC_BITS   = DEF_COEF_FRAC_BITS;
    // Far above the slowest legal run: about a thousand beats under heavy
    // stalls on both sides, two long output hold-offs and the config writes.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 100;

    // Register indexes past the end of the map; writes to them are dropped.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Q4.28 values used by the directed tests.
    localparam logic [COEF_W-1:0] COEF_ONE     = 32'h1000_0000;
    localparam logic [COEF_W-1:0] COEF_HALF    = 32'h0800_0000;
    localparam logic [COEF_W-1:0] COEF_QUARTER = 32'h0400_0000;
    localparam logic [COEF_W-1:0] COEF_M_HALF  = 32'hF800_0000;
    localparam logic [COEF_W-1:0] COEF_M_QUART = 32'hFC00_0000;
    localparam logic [COEF_W-1:0] COEF_MAX     = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN     = 32'h8000_0000;
    localparam logic [COEF_W-1:0] COEF_ZERO    = 32'h0000_0000;

    localparam logic signed [SAMPLE_W-1:0] PCM_MAX = SAMPLE_W'(SAMPLE_MAX);
    localparam logic signed [SAMPLE_W-1:0] PCM_MIN = SAMPLE_W'(SAMPLE_MIN);

    // One output beat as the filter should produce it.
    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } sample_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  write_enable;
    logic [REG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] write_data;

    mbq_in_if  in_ch ();
    mbq_out_if out_ch ();

    multichannel_biquad_filter #(
        .CHANNELS       (CHANNELS),
        .COEF_FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (in_ch),
        .filtered     (out_ch),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    // Shadow copy of the filter: shared coefficients, enable mask and the
    // per-channel two-deep input and output history.
    coef_set_t           shadow_coef;
    logic [ENABLE_W-1:0] shadow_enable;
    hist_t               shadow_hist [CHANNELS];

    // Output beats predicted at input acceptance, oldest first.
    sample_beat_t predicted_beats[$];

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Idling knobs, in percent per cycle, changed between test phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // A nonzero value asks the output side to hold ready low that many cycles.
    int hold_request   = 0;

    logic [CH_W-1:0] prev_channel = '0;

    // ------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Behavioral filter
    // ------------------------------------------------------------------
    task automatic clear_shadow();
        shadow_coef    = '0;
        shadow_coef.b0 = B0_RESET;
        shadow_enable  = ENABLE_RESET;
        for (int c = 0; c < CHANNELS; c++)
        begin
            shadow_hist[c] = '0;
        end
    endtask

    // Runs one sample through the shadow filter and returns the beat it
    // should produce. The accumulator is exact: five 56-bit products fit
    // comfortably in 64 bits. An arithmetic shift of the rounded sum gives
    // the floor, so ties land toward plus infinity.
    function automatic sample_beat_t biquad_predict(input logic [CH_W-1:0] ch,
                                                    input logic signed [SAMPLE_W-1:0] x,
                                                    input logic last);
        sample_beat_t beat;
        hist_t        h;
        longint       acc;
        longint       y;
        beat.channel = ch;
        beat.sample  = x;
        beat.last    = last;
        // A disabled channel passes through and keeps its history as it is.
        if (shadow_enable[ch])
        begin
            h   = shadow_hist[ch];
            acc = longint'($signed(shadow_coef.b0)) * longint'($signed(x))
                + longint'($signed(shadow_coef.b1)) * longint'($signed(h.x1))
                + longint'($signed(shadow_coef.b2)) * longint'($signed(h.x2))
                - longint'($signed(shadow_coef.a1)) * longint'($signed(h.y1))
                - longint'($signed(shadow_coef.a2)) * longint'($signed(h.y2));
            acc = acc + (longint'(1) <<< (FRAC_BITS - 1));
            y   = acc >>> FRAC_BITS;
            if (y > SAMPLE_MAX)
            begin
                y = SAMPLE_MAX;
            end
            if (y < SAMPLE_MIN)
            begin
                y = SAMPLE_MIN;
            end
            // The saturated value, not the raw sum, becomes output history.
            h.x2 = h.x1;
            h.x1 = x;
            h.y2 = h.y1;
            h.y1 = y[SAMPLE_W-1:0];
            shadow_hist[ch] = h;
            beat.sample     = y[SAMPLE_W-1:0];
        end
        return beat;
    endfunction

    // ------------------------------------------------------------------
    // Input monitor: every accepted beat gets its prediction queued here.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            predicted_beats.push_back(biquad_predict(in_ch.channel, in_ch.sample_in,
                                                     in_ch.last_sample));
        end
    end

    // ------------------------------------------------------------------
    // Output checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        // Past the print cap the count still goes up, so the verdict holds.
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        sample_beat_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (predicted_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat ch %0d sample %0d last %0b",
                                          out_ch.channel_out, out_ch.sample_out,
                                          out_ch.last_out));
            end
            else
            begin
                want = predicted_beats.pop_front();
                if (out_ch.channel_out !== want.channel)
                begin
                    report_mismatch($sformatf("channel %0d, want %0d",
                                              out_ch.channel_out, want.channel));
                end
                if (out_ch.sample_out !== want.sample)
                begin
                    report_mismatch($sformatf("ch %0d sample %0d, want %0d", want.channel,
                                              out_ch.sample_out, want.sample));
                end
                if (out_ch.last_out !== want.last)
                begin
                    report_mismatch($sformatf("ch %0d last %0b, want %0b", want.channel,
                                              out_ch.last_out, want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side ready. Random stalls follow recv_stall_pct; a hold-off
    // request is counted down here, one cycle per edge, with ready low.
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // Offers one beat and returns at the edge where it is accepted. Valid is
    // left high so back-to-back beats need no extra cycle; random idle cycles
    // are inserted in front according to send_idle_pct.
    task automatic send_sample(input logic [CH_W-1:0] ch,
                               input logic signed [SAMPLE_W-1:0] x,
                               input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid       <= 1'b1;
        in_ch.channel     <= ch;
        in_ch.sample_in   <= x;
        in_ch.last_sample <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        prev_channel = ch;
    endtask

    // Drops valid and waits until every predicted beat has come out. Each
    // input beat yields exactly one output beat, so an empty queue means
    // nothing is left inside the filter.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (predicted_beats.size() != 0);
    endtask

    // One register write. The shadow copy changes at the same edge as the
    // filter's register. Only called with the filter drained.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= data;
        @(posedge clk);
        write_enable <= 1'b0;
        unique case (idx)
            REG_B0:     shadow_coef.b0 = data;
            REG_B1:     shadow_coef.b1 = data;
            REG_B2:     shadow_coef.b2 = data;
            REG_A1:     shadow_coef.a1 = data;
            REG_A2:     shadow_coef.a2 = data;
            REG_ENABLE: shadow_enable  = data[ENABLE_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic write_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                               input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                               input logic [COEF_W-1:0] a2);
        write_reg(REG_B0, b0);
        write_reg(REG_B1, b1);
        write_reg(REG_B2, b2);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
    endtask

    // Mostly coefficients within about +-0.5 so the feedback stays tame and
    // outputs are not all clipped; the rest are the extremes or any pattern.
    function automatic logic [COEF_W-1:0] random_coef();
        case ($urandom_range(9)) inside
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            [2:3]:   return $urandom();
            default: return COEF_W'(int'($urandom_range(0, 268435456)) - 134217728);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9)) inside
            0:       return PCM_MAX;
            1:       return PCM_MIN;
            [2:4]:   return SAMPLE_W'(int'($urandom_range(0, 4096)) - 2048);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // A quarter of the beats stay on the previous channel, so the filter also
    // sees same-channel runs that must wait for the history write-back.
    function automatic logic [CH_W-1:0] random_channel();
        if ($urandom_range(3) == 0)
        begin
            return prev_channel;
        end
        return CH_W'($urandom());
    endfunction

    task automatic send_random_samples(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_sample(random_channel(), random_sample(), 1'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset every channel is disabled, so samples pass unchanged,
    // including both full-scale values.
    task automatic test_reset_pass_through();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_sample(3'd0, PCM_MAX, 1'b0);
        send_sample(3'd7, PCM_MIN, 1'b1);
        send_sample(3'd5, '0, 1'b0);
        send_sample(3'd2, -24'sd1, 1'b1);
        wait_drained();
    endtask

    // Rounding of exact halves, and clipping with the largest coefficients of
    // either sign against full-scale samples. Only b0 is nonzero here, so the
    // history does not enter the result.
    task automatic test_rounding_and_saturation();
        write_coefs(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
        write_reg(REG_ENABLE, 32'h0000_00FF);
        // 0.5 and -0.5 are ties and go up: to 1 and to 0.
        send_sample(3'd1, 24'sd1, 1'b0);
        send_sample(3'd1, -24'sd1, 1'b0);
        // 1.5 and -1.5 go to 2 and to -1.
        send_sample(3'd1, 24'sd3, 1'b0);
        send_sample(3'd1, -24'sd3, 1'b1);
        wait_drained();
        write_reg(REG_B0, COEF_MAX);
        send_sample(3'd6, PCM_MAX, 1'b0);
        send_sample(3'd6, PCM_MIN, 1'b1);
        wait_drained();
        // The most negative coefficient times the most negative sample is the
        // largest positive product and clips high.
        write_reg(REG_B0, COEF_MIN);
        send_sample(3'd4, PCM_MAX, 1'b0);
        send_sample(3'd4, PCM_MIN, 1'b1);
        wait_drained();
    endtask

    // Impulse response of one channel with all five taps active, interleaved
    // with a disabled channel. Writes to the unused indexes must change
    // nothing, and disabling a channel must keep its history intact.
    task automatic test_history_and_enable();
        write_coefs(COEF_ONE, COEF_HALF, COEF_M_QUART, COEF_M_HALF, COEF_QUARTER);
        write_reg(REG_ENABLE, 32'h0000_0008);
        send_sample(3'd3, 24'sd1000000, 1'b0);
        send_sample(3'd2, 24'sd12345, 1'b0);
        send_sample(3'd3, '0, 1'b0);
        send_sample(3'd3, '0, 1'b0);
        send_sample(3'd3, '0, 1'b1);
        wait_drained();
        write_reg(REG_SPARE_LO, $urandom());
        write_reg(REG_SPARE_HI, $urandom());
        write_reg(REG_ENABLE, 32'h0000_0000);
        send_sample(3'd3, 24'sd777, 1'b0);
        wait_drained();
        // Back on: the output continues from the history left before.
        write_reg(REG_ENABLE, 32'hFFFF_FF08);
        send_sample(3'd3, '0, 1'b1);
        wait_drained();
    endtask

    // Random traffic under one idling mode and one register setting. With
    // use_extremes the coefficients alternate between the two full-scale
    // values and every channel is filtered.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int count, input bit use_extremes);
        wait_drained();
        if (use_extremes)
        begin
            write_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
            write_reg(REG_ENABLE, 32'h0000_00FF);
        end
        else
        begin
            write_coefs(random_coef(), random_coef(), random_coef(), random_coef(),
                        random_coef());
            write_reg(REG_ENABLE, $urandom());
        end
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        send_random_samples(count);
    endtask

    // The output side holds ready low for a long stretch while the input side
    // keeps offering beats back to back, so the pipeline fills and stalls its
    // input. Later the input side stops until every result is out, then
    // traffic resumes into an empty pipeline with the history still in place.
    task automatic test_output_backpressure();
        wait_drained();
        write_coefs(random_coef(), random_coef(), random_coef(), random_coef(),
                    random_coef());
        write_reg(REG_ENABLE, 32'h0000_00F5);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        send_random_samples(40);
        wait_drained();
        hold_request = 150;
        send_random_samples(30);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.channel     <= '0;
        in_ch.sample_in   <= '0;
        in_ch.last_sample <= 1'b0;
        write_enable      <= 1'b0;
        reg_index         <= REG_B0;
        write_data        <= '0;
        clear_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_pass_through();
        test_rounding_and_saturation();
        test_history_and_enable();
        test_random_traffic(0, 0, 220, 1'b0);
        test_random_traffic(71, 0, 220, 1'b1);
        test_random_traffic(0, 71, 220, 1'b0);
        test_random_traffic(24, 24, 220, 1'b0);
        test_output_backpressure();

        // Let the last beats out, then give a stray extra beat time to show.
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mbq_pkg.sv
hw/rtl/mbq_if.sv
hw/rtl/mbq_hist_mem.sv
hw/rtl/mbq_mac.sv
hw/rtl/multichannel_biquad_filter.sv
tb/multichannel_biquad_filter_tb.sv
